// File: design/assert_macros.svh
// Assertion macros used by the checker module.
// Standalone header; no other file is needed to use it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: label");

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: label");

// Implication checked on every clock edge, reset included.
`define ASSERT_IMPLY_RST(label, clk, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed: label");

`endif

// File: design/cpf_pkg.sv
// Shared types, constants and the check-digit function for the CPF validator.
// No dependencies.
package cpf_pkg;

  localparam int ID_W       = 37;
  localparam int NUM_DIGITS = 11;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int NUM_CELLS  = ID_W;

  // Data handed from one conversion cell to the next.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [ID_W-1:0]  bin;
  } cpf_dd_t;

  // Check digit from a weighted sum: 11 - (s mod 11), with 10 and 11 mapped to 0.
  // The quotient estimate s*93/1024 is exact or one low for s below 1024.
  function automatic logic [3:0] cpf_chk(input logic [9:0] s);
    logic [16:0] prod;
    logic [6:0]  q;
    logic [10:0] t;
    logic [4:0]  r;
    prod = 17'(s) * 17'd93;
    q    = prod[16:10];
    t    = {1'b0, s} - (11'(q) * 11'd11);
    r    = t[4:0];
    if (r >= 5'd11) begin
      r = r - 5'd11;
    end
    if (r < 5'd2) begin
      return 4'd0;
    end
    return 4'(5'd11 - r);
  endfunction

endpackage

// File: design/cpf_dd_cell.sv
// One cell of the binary-to-decimal chain: decimal adjust and one-bit shift.
// Depends on cpf_pkg.
module cpf_dd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpf_pkg::cpf_dd_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cpf_pkg::cpf_dd_t out_data
);
  import cpf_pkg::*;

  logic [BCD_W-1:0] adj;
  cpf_dd_t          data_next;

  always_comb begin
    adj = in_data.bcd;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      if (adj[4*j +: 4] >= 4'd5) begin
        adj[4*j +: 4] = adj[4*j +: 4] + 4'd3;
      end
    end
    // The top bit of the decimal field falls off: digits above eleven are ignored.
    data_next.bcd = {adj[BCD_W-2:0], in_data.bin[ID_W-1]};
    data_next.bin = {in_data.bin[ID_W-2:0], 1'b0};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// File: design/cpf_check_unit.sv
// Three-stage back end: weighted digit sums, first check digit, second check digit and compare.
// Depends on cpf_pkg.
module cpf_check_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cpf_pkg::cpf_dd_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             is_valid,
  output logic [3:0]       first_check,
  output logic [3:0]       second_check
);
  import cpf_pkg::*;

  logic       v1, v2;
  logic       rdy1, rdy2, rdy3;
  logic [9:0] sum1, sum2, s2;
  logic [7:0] tail1, tail2;
  logic [3:0] c1;

  logic [9:0] sum1_next, sum2_next, s2_next;
  logic [6:0] dsum;
  logic [3:0] c1_next, c2_next;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Digit j (from the least significant) weighs j for the first sum and j+1 for
  // the second, so the second sum is the first plus the plain digit sum.
  always_comb begin
    sum1_next = '0;
    dsum      = '0;
    for (int j = 2; j < NUM_DIGITS; j++) begin
      sum1_next = sum1_next + 10'(in_data.bcd[4*j +: 4]) * 10'(j);
      dsum      = dsum + 7'(in_data.bcd[4*j +: 4]);
    end
    sum2_next = sum1_next + 10'(dsum);
  end

  always_comb begin
    c1_next = cpf_chk(sum1);
    s2_next = sum2 + {5'd0, c1_next, 1'b0};
    c2_next = cpf_chk(s2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
    if (rdy1 && in_valid) begin
      sum1  <= sum1_next;
      sum2  <= sum2_next;
      tail1 <= in_data.bcd[7:0];
    end
    if (rdy2 && v1) begin
      c1    <= c1_next;
      s2    <= s2_next;
      tail2 <= tail1;
    end
    if (rdy3 && v2) begin
      first_check  <= c1;
      second_check <= c2_next;
      is_valid     <= (c1 == tail2[7:4]) && (c2_next == tail2[3:0]);
    end
  end

endmodule

// File: design/cpf_check_digit_validate.sv
// CPF check-digit validator: 37 binary-to-decimal cells followed by a 3-stage back end.
// Throughput is one number per cycle while the output is not stalled; every stage has
// its own valid bit and takes a new beat whenever it is empty or its contents move on.
// Synchronous reset clears all valid bits; payload registers are not reset.
module cpf_check_digit_validate (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [36:0] id_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_valid,
  output logic [3:0]  first_check,
  output logic [3:0]  second_check
);
  import cpf_pkg::*;

  logic    chain_valid [NUM_CELLS+1];
  logic    chain_ready [NUM_CELLS+1];
  cpf_dd_t chain_data  [NUM_CELLS+1];

  assign chain_valid[0]    = in_valid;
  assign in_ready          = chain_ready[0];
  assign chain_data[0].bcd = '0;
  assign chain_data[0].bin = id_number;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    cpf_dd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  cpf_check_unit u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (chain_valid[NUM_CELLS]),
    .in_ready     (chain_ready[NUM_CELLS]),
    .in_data      (chain_data[NUM_CELLS]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_valid     (is_valid),
    .first_check  (first_check),
    .second_check (second_check)
  );

endmodule

// File: design/cpf_port_checker.sv
// Port-level checks for the CPF validator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cpf_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_valid,
  input logic [3:0] first_check,
  input logic [3:0] second_check
);

  logic [8:0] out_payload;

  assign out_payload = {is_valid, first_check, second_check};

  `ASSERT_IMPLY(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLY(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_payload))
  `ASSERT_ALWAYS(a_digit_range, clk, rst, !out_valid || (first_check <= 4'd9 && second_check <= 4'd9))
  `ASSERT_IMPLY_RST(a_reset_empty, clk, rst, !out_valid)

endmodule

bind cpf_check_digit_validate cpf_port_checker u_port_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .is_valid     (is_valid),
  .first_check  (first_check),
  .second_check (second_check)
);

// File: tb/cpf_check_digit_validate_tb.sv
// Self-checking testbench for the CPF check-digit validator.
// Depends only on the RTL: cpf_check_digit_validate and the cpf_pkg package it uses.
// Computes the expected check digits itself and compares every output beat in order.
module cpf_check_digit_validate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct {
    logic [36:0] id;
    logic        is_valid;
    logic [3:0]  first_check;
    logic [3:0]  second_check;
  } cpf_expect_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [36:0] id_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_valid;
  logic [3:0]  first_check;
  logic [3:0]  second_check;

  cpf_expect_t pending_checks[$];
  int          send_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  int          numbers_sent = 0;
  int          results_checked = 0;
  int          valid_results = 0;
  int          mismatches = 0;

  cpf_check_digit_validate DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .id_number    (id_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_valid     (is_valid),
    .first_check  (first_check),
    .second_check (second_check)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // 11 minus the remainder modulo 11, where 10 and 11 fold to zero.
  function automatic logic [3:0] mod11_digit(input int unsigned wsum);
    int unsigned v;
    v = 11 - (wsum % 11);
    if (v >= 10) begin
      v = 0;
    end
    return 4'(v);
  endfunction

  function automatic cpf_expect_t predict_check_digits(input logic [36:0] n);
    longint unsigned rest;
    int unsigned     d;
    int unsigned     wsum_first;
    int unsigned     wsum_second;
    int unsigned     tail;
    cpf_expect_t     e;
    // Only the nine digits above the last two count; higher digits fall off.
    rest = 64'(n) / 64'd100;
    wsum_first = 0;
    wsum_second = 0;
    for (int k = 0; k < 9; k++) begin
      d = int'(rest % 64'd10);
      rest = rest / 64'd10;
      wsum_first += d * (k + 2);
      wsum_second += d * (k + 3);
    end
    e.id = n;
    e.first_check = mod11_digit(wsum_first);
    e.second_check = mod11_digit(wsum_second + 2 * e.first_check);
    tail = int'(64'(n) % 64'd100);
    e.is_valid = ((e.first_check * 10 + e.second_check) == tail);
    return e;
  endfunction

  function automatic logic [36:0] with_check_digits(input int unsigned base9);
    logic [36:0] n;
    cpf_expect_t e;
    n = 37'(base9) * 37'd100;
    e = predict_check_digits(n);
    return n + 37'(e.first_check) * 37'd10 + 37'(e.second_check);
  endfunction

  // Well-formed numbers for 45 in 100 picks; the rest are oversized, corrupted or arbitrary.
  function automatic logic [36:0] random_cpf_number();
    int unsigned pick;
    logic [63:0] wide;
    logic [36:0] n;
    pick = $urandom_range(99);
    n = with_check_digits($urandom_range(999999999));
    if (pick < 45) begin
      return n;
    end else if (pick < 55) begin
      wide = 64'(n) + 64'd100000000000;
      if (wide <= 64'h1F_FFFF_FFFF) begin
        n = wide[36:0];
      end
      return n;
    end else if (pick < 65) begin
      return n - (n % 37'd100) + 37'($urandom_range(99));
    end else if (pick < 85) begin
      wide = {$urandom, $urandom};
      return 37'(wide % 64'd100000000000);
    end
    wide = {$urandom, $urandom};
    return wide[36:0];
  endfunction

  task automatic send_number(input logic [36:0] n);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    id_number <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Records each accepted input beat and checks each accepted output beat.
  always @(posedge clk) begin
    cpf_expect_t e;
    if (!rst && in_valid && in_ready) begin
      pending_checks.push_back(predict_check_digits(id_number));
      numbers_sent++;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_checks.size() == 0) begin
        $error("output beat with no number outstanding");
        mismatches++;
      end else begin
        e = pending_checks.pop_front();
        results_checked++;
        if (is_valid === 1'b1) begin
          valid_results++;
        end
        if (is_valid !== e.is_valid) begin
          $error("is_valid mismatch for %0d: expected %0d, got %0d", e.id, e.is_valid, is_valid);
          mismatches++;
        end
        if (first_check !== e.first_check) begin
          $error("first_check mismatch for %0d: expected %0d, got %0d",
                 e.id, e.first_check, first_check);
          mismatches++;
        end
        if (second_check !== e.second_check) begin
          $error("second_check mismatch for %0d: expected %0d, got %0d",
                 e.id, e.second_check, second_check);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_corner_numbers();
    logic [36:0] corner_ids [14] = '{
      37'd0, 37'h1F_FFFF_FFFF, 37'd99999999999, 37'd11144477735, 37'd11144477736,
      37'd11144477705, 37'd11111111111, 37'd22222222222, 37'd111144477735,
      37'd100000000000, 37'd1, 37'd99, 37'd12345678909, 37'd52998224725
    };
    send_pct = 0;
    stall_pct <= 0;
    foreach (corner_ids[i]) begin
      send_number(corner_ids[i]);
    end
  endtask

  task automatic test_random_traffic(input int count, input int sender_idle,
                                     input int receiver_stall);
    send_pct = sender_idle;
    stall_pct <= receiver_stall;
    repeat (count) begin
      send_number(random_cpf_number());
    end
  endtask

  // The output is held off for a long stretch while the sender keeps going,
  // so the pipeline fills and the input must stall.
  task automatic test_output_hold();
    send_pct = 0;
    stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (150) begin
      send_number(random_cpf_number());
    end
  endtask

  task automatic test_drain_pause();
    send_pct = 33;
    stall_pct <= 33;
    repeat (15) begin
      send_number(random_cpf_number());
    end
    wait_for_drain();
    repeat (15) begin
      send_number(random_cpf_number());
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_corner_numbers();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 70, 0);
    test_random_traffic(240, 0, 70);
    test_random_traffic(240, 33, 33);
    test_output_hold();
    test_drain_pause();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d numbers and checked %0d results, %0d of them valid CPFs,",
             numbers_sent, results_checked, valid_results);
    $display("under four idle patterns, a long output hold-off and a full drain pause.");
    if (mismatches == 0 && pending_checks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
